### rtl/assert_macros.svh
// Assertion macros shared by the checker files of the alarm scheduler.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an asynchronous active-low reset that disables it.
`define ATNS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: when cond holds, prop must hold.
`define ATNS_ASSERT_IMP(lbl, clk, rst_n, cond, prop, msg) \
	`ATNS_ASSERT(lbl, clk, rst_n, (cond) |-> (prop), msg)

`endif

### rtl/atns_pkg.sv
// Types and constants of the alarm table and next-alarm scheduler.
// Depends on nothing; used by the table memory, the top level and the checker.
package atns_pkg;

	localparam logic [2:0] CMD_SET    = 3'd0;
	localparam logic [2:0] CMD_DELETE = 3'd1;
	localparam logic [2:0] CMD_SCHED  = 3'd2;
	localparam logic [2:0] CMD_DUP    = 3'd3;
	localparam logic [2:0] CMD_EXPIRY = 3'd4;
	localparam logic [2:0] CMD_READ   = 3'd5;

	localparam logic [1:0] MODE_OFF    = 2'd0;
	localparam logic [1:0] MODE_REPEAT = 2'd1;
	localparam logic [1:0] MODE_ONCE   = 2'd2;

	typedef struct packed {
		logic [2:0] cmd;
		logic [2:0] slot;
		logic [4:0] alarm_hour;
		logic [5:0] alarm_minute;
		logic [1:0] alarm_mode;
		logic [7:0] day_mask;
		logic [2:0] today;
		logic [4:0] now_hour;
		logic [5:0] now_minute;
	} req_t;

	typedef struct packed {
		logic       arm;
		logic [2:0] out_slot;
		logic [4:0] out_hour;
		logic [5:0] out_minute;
		logic [7:0] out_mask;
		logic [1:0] out_mode;
		logic       answer;
		logic [3:0] entries;
		logic       fault;
	} rsp_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [1:0] mode;
		logic [7:0] mask;
	} entry_t;

endpackage

### rtl/atns_store.sv
// Alarm table memory: one write port, one read port, registered read data.
// Depends on atns_pkg for the entry type.
module atns_store #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  atns_pkg::entry_t    wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output atns_pkg::entry_t    rdata
);
	import atns_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/alarm_table_next_alarm_scheduler_top.sv
// Top level of the alarm table and next-alarm scheduler.
// Depends on atns_pkg and atns_store.
//
// Usage: drive a command word on req and raise start; it is taken at a clock
// edge where start is high and busy is low. busy stays high while the command
// runs. The result word appears on rsp for exactly one cycle, marked by done;
// the receiver cannot stall it, so it must take the word in that cycle.
// Set, unknown and faulting commands finish without leaving the idle state. Read,
// and expiry with a one-shot pending, make one table read; expiry with nothing
// pending finishes from idle. The duplicate check scans the whole table; delete
// reads each entry after the slot and moves it one place down; schedule scans
// the table, then reads the chosen entry only when the choice is taken.
// The scans stream one table entry per cycle through the single read port of
// the table memory. Only one command is in flight at a time. Reset clears the
// count, the armed slot, the one-shot tracking and the first-alarm flag at once;
// the table contents are left as they are, and no command ever reads an entry
// that was not written.
module alarm_table_next_alarm_scheduler_top #(
	parameter int ALARMS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  atns_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output atns_pkg::rsp_t rsp
);
	import atns_pkg::*;

	localparam int IW = (ALARMS > 1) ? $clog2(ALARMS) : 1;
	localparam int CW = $clog2(ALARMS + 1);
	localparam int SW = (CW > 3) ? CW : 3;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_PICK = 5'b00100,
		S_ARM  = 5'b01000,
		S_LOOK = 5'b10000
	} state_t;

	state_t        state_q;
	req_t          req_q;
	rsp_t          rsp_q;
	logic          done_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] armed_q;
	logic          once_pend_q;
	logic [IW-1:0] once_slot_q;
	logic          first_done_q;

	logic [CW-1:0] idx_q;
	logic [IW-1:0] idx_s1;
	logic          vld_s1;
	logic [10:0]   earl_key_q;
	logic [IW-1:0] earl_idx_q;
	logic [10:0]   lat_key_q;
	logic [IW-1:0] lat_idx_q;
	logic          have_lat_q;
	logic          dup_q;
	logic [IW-1:0] pick_q;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	entry_t        mem_rdata;

	logic          accept;
	logic          set_fault;
	logic          idx_fault;
	logic          start_fault;
	logic          finish;
	rsp_t          start_rsp;
	entry_t        set_entry;
	logic          scan_re;
	logic [10:0]   now_key;
	logic [10:0]   row_key;
	logic [IW-1:0] pick_id;
	logic          first_alarm;

	atns_store #(
		.DEPTH (ALARMS),
		.AW    (IW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign accept    = start && (state_q == S_IDLE);
	assign set_fault = (SW'(req.slot) > SW'(count_q)) || (SW'(req.slot) >= SW'(ALARMS));
	assign idx_fault = SW'(req.slot) >= SW'(count_q);
	assign scan_re   = idx_q < count_q;
	assign now_key   = {req_q.now_hour, req_q.now_minute};
	assign row_key   = {mem_rdata.hour, mem_rdata.minute};
	assign pick_id   = have_lat_q ? lat_idx_q : earl_idx_q;
	assign first_alarm = (count_q == CW'(1)) && !first_done_q;

	// A zero weekday mask turns the alarm into a one-shot on today.
	always_comb begin
		set_entry.hour   = req.alarm_hour;
		set_entry.minute = req.alarm_minute;
		set_entry.mode   = req.alarm_mode;
		set_entry.mask   = req.day_mask;
		if (req.day_mask == 8'd0) begin
			set_entry.mode = MODE_ONCE;
			set_entry.mask = 8'(8'd1 << req.today);
		end
	end

	// Fault of a newly taken command, and whether the current cycle ends a command.
	always_comb begin
		start_fault = 1'b0;
		finish      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				case (req.cmd) inside
					CMD_SET: start_fault = set_fault;
					CMD_DELETE, CMD_READ: start_fault = idx_fault;
					CMD_SCHED: start_fault = (count_q == '0);
					default: start_fault = 1'b0;
				endcase
				if (accept) begin
					case (req.cmd) inside
						CMD_SET: finish = 1'b1;
						CMD_DELETE, CMD_READ, CMD_SCHED: finish = start_fault;
						CMD_DUP: finish = 1'b0;
						CMD_EXPIRY: finish = !once_pend_q;
						default: finish = 1'b1;
					endcase
				end
			end
			S_SCAN: finish = !vld_s1 && !scan_re && (req_q.cmd != CMD_SCHED);
			S_PICK: finish = !(first_alarm || (pick_id != armed_q));
			S_ARM:  finish = 1'b1;
			S_LOOK: finish = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		start_rsp       = '0;
		start_rsp.fault = start_fault;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = set_entry;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.cmd)
						CMD_SET: begin
							mem_we    = !set_fault;
							mem_waddr = IW'(req.slot);
						end
						CMD_EXPIRY: begin
							mem_re    = once_pend_q;
							mem_raddr = once_slot_q;
						end
						CMD_READ: begin
							mem_re    = !idx_fault;
							mem_raddr = IW'(req.slot);
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				mem_re    = scan_re;
				mem_raddr = idx_q[IW-1:0];
				// Delete moves the word just read one place down.
				if (req_q.cmd == CMD_DELETE && vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1 - IW'(1);
					mem_wdata = mem_rdata;
				end
			end
			S_PICK: begin
				mem_re    = first_alarm || (pick_id != armed_q);
				mem_raddr = pick_id;
			end
			S_ARM: begin
				mem_we           = (mem_rdata.mode == MODE_ONCE);
				mem_waddr        = pick_q;
				mem_wdata        = mem_rdata;
				mem_wdata.mode   = MODE_OFF;
				mem_wdata.mask   = 8'd0;
			end
			S_LOOK: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			done_q       <= 1'b0;
			count_q      <= '0;
			armed_q      <= '0;
			once_pend_q  <= 1'b0;
			once_slot_q  <= '0;
			first_done_q <= 1'b0;
			vld_s1       <= 1'b0;
		end else begin
			done_q <= finish;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q      <= req;
						rsp_q      <= start_rsp;
						vld_s1     <= 1'b0;
						have_lat_q <= 1'b0;
						dup_q      <= 1'b0;
						idx_q      <= (req.cmd == CMD_DELETE) ?
						              CW'(req.slot) + CW'(1) : '0;
						case (req.cmd)
							CMD_SET: begin
								if (!set_fault && SW'(req.slot) == SW'(count_q)) begin
									count_q <= count_q + CW'(1);
								end
							end
							CMD_DELETE: begin
								if (!idx_fault) begin
									state_q <= S_SCAN;
								end
							end
							CMD_SCHED: begin
								if (count_q != '0) begin
									state_q <= S_SCAN;
								end
							end
							CMD_DUP: state_q <= S_SCAN;
							CMD_EXPIRY: begin
								if (once_pend_q) begin
									state_q <= S_LOOK;
								end
							end
							CMD_READ: begin
								if (!idx_fault) begin
									state_q <= S_LOOK;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					vld_s1 <= scan_re;
					idx_s1 <= idx_q[IW-1:0];
					if (scan_re) begin
						idx_q <= idx_q + CW'(1);
					end
					if (vld_s1) begin
						if (idx_s1 == '0 || row_key < earl_key_q) begin
							earl_key_q <= row_key;
							earl_idx_q <= idx_s1;
						end
						if (row_key > now_key && (!have_lat_q || row_key < lat_key_q)) begin
							lat_key_q  <= row_key;
							lat_idx_q  <= idx_s1;
							have_lat_q <= 1'b1;
						end
						if (SW'(idx_s1) != SW'(req_q.slot) &&
						    mem_rdata.hour == req_q.alarm_hour &&
						    mem_rdata.minute == req_q.alarm_minute) begin
							dup_q <= 1'b1;
						end
					end
					if (!vld_s1 && !scan_re) begin
						case (req_q.cmd)
							CMD_SCHED: state_q <= S_PICK;
							CMD_DELETE: begin
								count_q <= count_q - CW'(1);
								state_q <= S_IDLE;
							end
							default: begin
								rsp_q.answer <= dup_q;
								state_q      <= S_IDLE;
							end
						endcase
					end
				end
				S_PICK: begin
					if (first_alarm) begin
						first_done_q <= 1'b1;
					end
					if (first_alarm || pick_id != armed_q) begin
						pick_q  <= pick_id;
						state_q <= S_ARM;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_ARM: begin
					if (mem_rdata.mode == MODE_REPEAT || mem_rdata.mode == MODE_ONCE) begin
						rsp_q.arm        <= 1'b1;
						rsp_q.out_slot   <= 3'(pick_q);
						rsp_q.out_hour   <= mem_rdata.hour;
						rsp_q.out_minute <= mem_rdata.minute;
						rsp_q.out_mask   <= mem_rdata.mask;
						once_pend_q      <= (mem_rdata.mode == MODE_ONCE);
						if (mem_rdata.mode == MODE_ONCE) begin
							once_slot_q <= pick_q;
						end
					end
					armed_q <= pick_q;
					state_q <= S_IDLE;
				end
				S_LOOK: begin
					if (req_q.cmd == CMD_EXPIRY) begin
						rsp_q.answer <= (now_key >= row_key);
					end else begin
						rsp_q.out_slot   <= req_q.slot;
						rsp_q.out_hour   <= mem_rdata.hour;
						rsp_q.out_minute <= mem_rdata.minute;
						rsp_q.out_mask   <= mem_rdata.mask;
						rsp_q.out_mode   <= mem_rdata.mode;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	// The entry count is live, so the word shows the count after the command.
	always_comb begin
		rsp         = rsp_q;
		rsp.entries = 4'(count_q);
	end

endmodule

### rtl/atns_checker.sv
// Port-level checker for the alarm scheduler top level, with its bind.
// Depends on atns_pkg and assert_macros.svh.
`include "assert_macros.svh"

module atns_checker #(
	parameter int ALARMS = 8
) (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input atns_pkg::req_t req,
	input logic           busy,
	input logic           done,
	input atns_pkg::rsp_t rsp
);
	import atns_pkg::*;

	// A finished command always returns the block to accepting commands.
	`ATNS_ASSERT_IMP(done_frees, clk, arst_n, done, !busy, "done while busy")
	// An accepted command either finishes next cycle or keeps the block busy.
	`ATNS_ASSERT_IMP(accept_runs, clk, arst_n, start && !busy, ##1 (busy || done), "command lost")
	// No result word appears without a command having run.
	`ATNS_ASSERT_IMP(no_spurious, clk, arst_n, !busy && !start, ##1 !done, "word without command")
	// A faulting command never arms an alarm.
	`ATNS_ASSERT_IMP(fault_no_arm, clk, arst_n, done && rsp.fault, !rsp.arm, "armed on fault")
	// The count never exceeds the table size.
	`ATNS_ASSERT(count_bound, clk, arst_n, 32'(rsp.entries) <= ALARMS, "count beyond table")

endmodule

bind alarm_table_next_alarm_scheduler_top atns_checker #(.ALARMS(ALARMS)) u_atns_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.req    (req),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

### dv/tb_top.sv
// Self-checking testbench for the alarm table and next-alarm scheduler.
// Depends on atns_pkg and alarm_table_next_alarm_scheduler_top; an internal alarm table
// predicts every result word, and the predictions are compared as the words come back.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import atns_pkg::*;

	localparam int ALARMS = 8;
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	alarm_table_next_alarm_scheduler_top #(.ALARMS(ALARMS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	// Predicted alarm table and scheduler state.
	entry_t alarm_tab [ALARMS];
	int alarm_total;
	logic [2:0] armed_at;
	logic once_live;
	logic [2:0] once_at;
	logic first_armed;

	rsp_t awaited_words [$];
	int mismatches;
	int words_checked;
	int cmd_sent [8];
	int arms_seen;
	int burst_left;

	function automatic logic [10:0] clock_key(logic [4:0] h, logic [5:0] m);
		return {h, m};
	endfunction

	// Earliest alarm strictly after now, else the earliest overall; ties keep the lower index.
	function automatic logic [2:0] choose_next(logic [10:0] now);
		int earliest;
		int later;
		bit have_later;
		logic [10:0] k;
		earliest = 0;
		later = 0;
		have_later = 0;
		for (int i = 0; i < alarm_total; i++) begin
			k = clock_key(alarm_tab[i].hour, alarm_tab[i].minute);
			if (k < clock_key(alarm_tab[earliest].hour, alarm_tab[earliest].minute))
				earliest = i;
			if (k > now && (!have_later ||
					k < clock_key(alarm_tab[later].hour, alarm_tab[later].minute))) begin
				later = i;
				have_later = 1;
			end
		end
		return have_later ? later[2:0] : earliest[2:0];
	endfunction

	function automatic rsp_t apply_command(req_t w);
		rsp_t r;
		entry_t e;
		logic [2:0] pick;
		bit first_pass;
		r = '0;
		case (w.cmd)
			CMD_SET: begin
				if (w.slot > alarm_total) begin
					r.fault = 1'b1;
				end else begin
					e.hour = w.alarm_hour;
					e.minute = w.alarm_minute;
					e.mode = w.alarm_mode;
					e.mask = w.day_mask;
					// An empty weekday mask turns the alarm into a one-shot for today.
					if (w.day_mask == 8'h00) begin
						e.mode = MODE_ONCE;
						e.mask = 8'd1 << w.today;
					end
					alarm_tab[w.slot] = e;
					if (w.slot == alarm_total)
						alarm_total++;
				end
			end
			CMD_DELETE: begin
				if (w.slot >= alarm_total) begin
					r.fault = 1'b1;
				end else begin
					for (int i = w.slot; i + 1 < alarm_total; i++)
						alarm_tab[i] = alarm_tab[i + 1];
					alarm_total--;
				end
			end
			CMD_SCHED: begin
				if (alarm_total == 0) begin
					r.fault = 1'b1;
				end else begin
					pick = choose_next(clock_key(w.now_hour, w.now_minute));
					first_pass = (alarm_total == 1) && !first_armed;
					if (first_pass)
						first_armed = 1'b1;
					if (first_pass || pick != armed_at) begin
						e = alarm_tab[pick];
						if (e.mode == MODE_REPEAT || e.mode == MODE_ONCE) begin
							r.arm = 1'b1;
							r.out_slot = pick;
							r.out_hour = e.hour;
							r.out_minute = e.minute;
							r.out_mask = e.mask;
							if (e.mode == MODE_REPEAT) begin
								once_live = 1'b0;
							end else begin
								once_live = 1'b1;
								once_at = pick;
								alarm_tab[pick].mode = MODE_OFF;
								alarm_tab[pick].mask = 8'h00;
							end
						end
						armed_at = pick;
					end
				end
			end
			CMD_DUP: begin
				for (int i = 0; i < alarm_total; i++)
					if (i != w.slot && alarm_tab[i].hour == w.alarm_hour &&
							alarm_tab[i].minute == w.alarm_minute)
						r.answer = 1'b1;
			end
			CMD_EXPIRY: begin
				if (once_live)
					r.answer = clock_key(w.now_hour, w.now_minute) >=
						clock_key(alarm_tab[once_at].hour, alarm_tab[once_at].minute);
			end
			CMD_READ: begin
				if (w.slot >= alarm_total) begin
					r.fault = 1'b1;
				end else begin
					r.out_slot = w.slot;
					r.out_hour = alarm_tab[w.slot].hour;
					r.out_minute = alarm_tab[w.slot].minute;
					r.out_mask = alarm_tab[w.slot].mask;
					r.out_mode = alarm_tab[w.slot].mode;
				end
			end
			default: begin
			end
		endcase
		r.entries = alarm_total[3:0];
		return r;
	endfunction

	function automatic req_t make_word(logic [2:0] cmd, logic [2:0] slot, logic [4:0] h,
			logic [5:0] m, logic [1:0] mode, logic [7:0] mask, logic [2:0] today,
			logic [4:0] nh, logic [5:0] nm);
		req_t w;
		w.cmd = cmd;
		w.slot = slot;
		w.alarm_hour = h;
		w.alarm_minute = m;
		w.alarm_mode = mode;
		w.day_mask = mask;
		w.today = today;
		w.now_hour = nh;
		w.now_minute = nm;
		return w;
	endfunction

	// Times mostly in range, often from a small pool so that ties turn up.
	function automatic logic [10:0] rand_time();
		logic [4:0] h;
		logic [5:0] m;
		case ($urandom_range(0, 11))
			0: begin
				h = 5'($urandom_range(0, 31));
				m = 6'($urandom_range(0, 63));
			end
			1, 2, 3, 4: begin
				h = 5'($urandom_range(6, 7));
				m = 6'($urandom_range(0, 1) * 30);
			end
			default: begin
				h = 5'($urandom_range(0, 23));
				m = 6'($urandom_range(0, 59));
			end
		endcase
		return {h, m};
	endfunction

	function automatic req_t random_word(logic [2:0] cmd);
		req_t w;
		w.cmd = cmd;
		w.slot = 3'($urandom_range(0, 7));
		{w.alarm_hour, w.alarm_minute} = rand_time();
		w.alarm_mode = ($urandom_range(0, 9) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
		w.day_mask = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
		w.today = ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
		{w.now_hour, w.now_minute} = rand_time();
		return w;
	endfunction

	// Puts the current time on, just before or just after a stored alarm.
	function automatic req_t near_time(req_t w, logic [2:0] idx);
		w.now_hour = alarm_tab[idx].hour;
		case ($urandom_range(0, 2))
			0: w.now_minute = alarm_tab[idx].minute - 6'd1;
			1: w.now_minute = alarm_tab[idx].minute;
			default: w.now_minute = alarm_tab[idx].minute + 6'd1;
		endcase
		return w;
	endfunction

	function automatic logic [2:0] table_slot();
		if (alarm_total == 0 || $urandom_range(0, 9) == 0)
			return 3'($urandom_range(0, 7));
		return 3'($urandom_range(0, alarm_total - 1));
	endfunction

	// Sends one word and records its prediction once it is taken. start is left high
	// inside a burst, so the next word follows without a dead cycle.
	task automatic issue(input req_t w);
		rsp_t want;
		int gap;
		req <= w;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		want = apply_command(w);
		awaited_words.push_back(want);
		cmd_sent[w.cmd]++;
		if (want.arm)
			arms_seen++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(1, 8);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h (word %0d)", name, want, got, words_checked);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (awaited_words.size() == 0) begin
				$error("result word arrived with none outstanding");
				mismatches++;
			end else begin
				want = awaited_words.pop_front();
				check_field("arm", want.arm, rsp.arm);
				check_field("out_slot", want.out_slot, rsp.out_slot);
				check_field("out_hour", want.out_hour, rsp.out_hour);
				check_field("out_minute", want.out_minute, rsp.out_minute);
				check_field("out_mask", want.out_mask, rsp.out_mask);
				check_field("out_mode", want.out_mode, rsp.out_mode);
				check_field("answer", want.answer, rsp.answer);
				check_field("entries", want.entries, rsp.entries);
				check_field("fault", want.fault, rsp.fault);
				words_checked++;
			end
		end
	end

	task automatic test_empty_table();
		issue(make_word(CMD_SCHED, 3'd0, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd12, 6'd0));
		issue(make_word(CMD_DELETE, 3'd0, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd0, 6'd0));
		issue(make_word(CMD_READ, 3'd0, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd0, 6'd0));
		issue(make_word(CMD_EXPIRY, 3'd0, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd23, 6'd59));
		issue(make_word(CMD_DUP, 3'd7, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd0, 6'd0));
		issue(make_word(CMD_SPARE_LO, 3'd7, 5'd23, 6'd59, MODE_ONCE, 8'hFF, 3'd7, 5'd23,
			6'd59));
	endtask

	task automatic test_table_edits();
		// A set past the end is refused; the first append uses an empty mask on weekday zero.
		issue(make_word(CMD_SET, 3'd1, 5'd7, 6'd30, MODE_REPEAT, 8'h3E, 3'd1, 5'd0, 6'd0));
		issue(make_word(CMD_SET, 3'd0, 5'd0, 6'd0, MODE_REPEAT, 8'h00, 3'd0, 5'd0, 6'd0));
		// The only alarm equals the armed slot, yet is armed the first time.
		issue(make_word(CMD_SCHED, 3'd0, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd23, 6'd59));
		issue(make_word(CMD_SET, 3'd1, 5'd23, 6'd59, MODE_REPEAT, 8'hFF, 3'd1, 5'd0, 6'd0));
		issue(make_word(CMD_SET, 3'd2, 5'd12, 6'd0, MODE_SPARE, 8'h80, 3'd1, 5'd0, 6'd0));
		issue(make_word(CMD_SET, 3'd1, 5'd16, 6'd32, MODE_REPEAT, 8'h50, 3'd7, 5'd0, 6'd0));
		issue(make_word(CMD_READ, 3'd2, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd0, 6'd0));
		issue(make_word(CMD_READ, 3'd5, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd0, 6'd0));
		issue(make_word(CMD_DUP, 3'd3, 5'd16, 6'd32, MODE_OFF, 8'h00, 3'd1, 5'd0, 6'd0));
		issue(make_word(CMD_DUP, 3'd1, 5'd16, 6'd32, MODE_OFF, 8'h00, 3'd1, 5'd0, 6'd0));
		issue(make_word(CMD_DELETE, 3'd6, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd0, 6'd0));
		issue(make_word(CMD_DELETE, 3'd0, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd0, 6'd0));
		issue(make_word(CMD_SPARE_HI, 3'd0, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd0, 6'd0));
	endtask

	task automatic test_scheduling();
		issue(make_word(CMD_SET, 3'd2, 5'd5, 6'd5, MODE_REPEAT, 8'h00, 3'd7, 5'd0, 6'd0));
		issue(make_word(CMD_SCHED, 3'd0, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd5, 6'd4));
		issue(make_word(CMD_EXPIRY, 3'd0, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd5, 6'd4));
		issue(make_word(CMD_EXPIRY, 3'd0, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd5, 6'd5));
		issue(make_word(CMD_SCHED, 3'd0, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd23, 6'd59));
		issue(make_word(CMD_SCHED, 3'd0, 5'd0, 6'd0, MODE_OFF, 8'h00, 3'd1, 5'd12, 6'd0));
	endtask

	task automatic test_random_mix(input int count);
		req_t w;
		int roll;
		int set_limit;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			// Shrink the share of sets once the table fills so its size keeps moving.
			set_limit = (alarm_total < 5) ? 35 : 20;
			if (roll < set_limit) begin
				w = random_word(CMD_SET);
				if ($urandom_range(0, 9) == 0)
					w.slot = 3'($urandom_range(0, 7));
				else if (alarm_total < ALARMS && $urandom_range(0, 3) != 0)
					w.slot = 3'(alarm_total);
				else
					w.slot = table_slot();
			end else if (roll < set_limit + 15) begin
				w = random_word(CMD_DELETE);
				w.slot = table_slot();
			end else if (roll < set_limit + 40) begin
				w = random_word(CMD_SCHED);
				if (alarm_total > 0 && $urandom_range(0, 1) == 0)
					w = near_time(w, 3'($urandom_range(0, alarm_total - 1)));
			end else if (roll < set_limit + 50) begin
				w = random_word(CMD_DUP);
				if (alarm_total > 0 && $urandom_range(0, 2) != 0) begin
					w.slot = table_slot();
					w.alarm_hour = alarm_tab[table_slot() % alarm_total].hour;
					w.alarm_minute = alarm_tab[table_slot() % alarm_total].minute;
					if ($urandom_range(0, 1) == 0) begin
						w.alarm_hour = alarm_tab[w.slot % alarm_total].hour;
						w.alarm_minute = alarm_tab[w.slot % alarm_total].minute;
					end
				end
			end else if (roll < set_limit + 60) begin
				w = random_word(CMD_EXPIRY);
				if (once_live && $urandom_range(0, 1) == 0)
					w = near_time(w, once_at);
			end else if (roll < set_limit + 72) begin
				w = random_word(CMD_READ);
				w.slot = table_slot();
			end else begin
				w = random_word(($urandom_range(0, 1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI);
			end
			issue(w);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		alarm_total = 0;
		armed_at = '0;
		once_live = 1'b0;
		once_at = '0;
		first_armed = 1'b0;
		mismatches = 0;
		words_checked = 0;
		arms_seen = 0;
		burst_left = 0;
		foreach (cmd_sent[i])
			cmd_sent[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_table_edits();
		// Hold the sender off until every word so far is back.
		wait_drain();
		test_scheduling();
		wait_drain();
		test_random_mix(880);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d set, %0d delete, %0d schedule (%0d armed), %0d duplicate,",
			cmd_sent[CMD_SET], cmd_sent[CMD_DELETE], cmd_sent[CMD_SCHED], arms_seen,
			cmd_sent[CMD_DUP]);
		$display("%0d expiry, %0d read and %0d unknown words; %0d results compared.",
			cmd_sent[CMD_EXPIRY], cmd_sent[CMD_READ],
			cmd_sent[CMD_SPARE_LO] + cmd_sent[CMD_SPARE_HI], words_checked);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
